// File: hw/rtl/vsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vsa_pkg
// Shared types and constants of the voice slot allocator: request and
// response payloads, the stored slot record and the request opcodes.
// ----------------------------------------------------------------------------
package vsa_pkg;

  // default pool size
  localparam int VSA_VOICE_SLOTS = 16;

  // fixed field widths
  localparam int CHAR_W    = 3;
  localparam int SAMPLE_W  = 4;
  localparam int NOTE_W    = 7;
  localparam int TIME_W    = 32;
  localparam int GAIN_W    = 16;
  localparam int RATIO_W   = 24;
  localparam int SLOT_NUM_W = 4;
  localparam int BUSY_W    = 5;
  localparam int MASK_W    = 16;

  // request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_TIME  = 1'b1;

  // one request
  typedef struct packed {
    logic                opcode;
    logic [CHAR_W-1:0]   character_id;
    logic [SAMPLE_W-1:0] sample_id;
    logic [NOTE_W-1:0]   note_number;
    logic [TIME_W-1:0]   note_start;
    logic [TIME_W-1:0]   note_length;
    logic [GAIN_W-1:0]   gain;
    logic [RATIO_W-1:0]  rate_ratio;
    logic [TIME_W-1:0]   now_time;
  } vsa_req_t;

  // one response
  typedef struct packed {
    logic                  granted;
    logic [SLOT_NUM_W-1:0] slot_number;
    logic [BUSY_W-1:0]     busy_count;
    logic [MASK_W-1:0]     released_mask;
  } vsa_rsp_t;

  // voice record held per slot
  typedef struct packed {
    logic [CHAR_W-1:0]   character_id;
    logic [SAMPLE_W-1:0] sample_id;
    logic [NOTE_W-1:0]   note_number;
    logic [TIME_W-1:0]   note_start;
    logic [TIME_W-1:0]   note_length;
    logic [GAIN_W-1:0]   gain;
    logic [RATIO_W-1:0]  rate_ratio;
  } slot_rec_t;

endpackage
`default_nettype wire

// File: hw/rtl/vsa_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vsa_in_if / vsa_out_if
// Valid/ready channels carrying voice allocator requests and responses.
// ----------------------------------------------------------------------------
interface vsa_in_if import vsa_pkg::*; ();
  logic     valid;
  logic     ready;
  vsa_req_t req;

  modport source (output valid, output req, input ready);
  modport sink   (input valid, input req, output ready);
endinterface

interface vsa_out_if import vsa_pkg::*; ();
  logic     valid;
  logic     ready;
  vsa_rsp_t rsp;

  modport source (output valid, output rsp, input ready);
  modport sink   (input valid, input rsp, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/voice_slot_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Voice slot allocator: keeps VOICE_SLOTS voice records and an active bit per
// slot. An allocate request walks the active bits from slot 0, one slot a
// cycle, and writes the voice into the first free slot. A time update reads
// every slot's start and length from the record memory, one slot a cycle,
// and a single 33-bit adder and comparer checks the end time in the cycle
// after the read. One request is worked on at a time and the input is not
// ready meanwhile; the response sits in an output register, so the next
// request is taken while the last response still waits.
// ----------------------------------------------------------------------------
// voice_slot_allocator
// First-free voice slot allocation and time-based release for a synth pool.
// ----------------------------------------------------------------------------
module voice_slot_allocator import vsa_pkg::*; #(
  parameter int VOICE_SLOTS = VSA_VOICE_SLOTS
) (
  input  logic      clk,
  input  logic      rst_n,
  vsa_in_if.sink    in_chan,
  vsa_out_if.source out_chan
);

  localparam int IDX_W = $clog2(VOICE_SLOTS);
  localparam int CNT_W = $clog2(VOICE_SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICE_SLOTS - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ALLOC = 3'd1;
  localparam logic [2:0] ST_TIME  = 3'd2;
  localparam logic [2:0] ST_TAIL  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]             state_r, state_nxt;
  vsa_req_t               req_r, req_nxt;
  logic [IDX_W-1:0]       scan_idx_r, scan_idx_nxt;
  logic                   chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]       chk_idx_r, chk_idx_nxt;
  logic [VOICE_SLOTS-1:0] slot_active_r, slot_active_nxt;
  logic [CNT_W-1:0]       active_cnt_r, active_cnt_nxt;
  logic                   res_grant_r, res_grant_nxt;
  logic [IDX_W-1:0]       res_slot_r, res_slot_nxt;
  logic [VOICE_SLOTS-1:0] rel_r, rel_nxt;
  logic                   out_vld_r, out_vld_nxt;
  vsa_rsp_t               out_rsp_r, out_rsp_nxt;

  // record memory
  slot_rec_t              slot_mem [VOICE_SLOTS];
  slot_rec_t              rd_rec_r;
  slot_rec_t              wr_rec;
  logic                   mem_we;

  logic [TIME_W:0]        end_sum;
  logic                   expire;
  logic [MASK_W-1:0]      rel_mask;

  // record written on a grant
  assign wr_rec = '{
    character_id: req_r.character_id,
    sample_id:    req_r.sample_id,
    note_number:  req_r.note_number,
    note_start:   req_r.note_start,
    note_length:  req_r.note_length,
    gain:         req_r.gain,
    rate_ratio:   req_r.rate_ratio
  };

  // shared end-time adder and compare
  assign end_sum = {1'b0, rd_rec_r.note_start} + {1'b0, rd_rec_r.note_length};
  assign expire  = ({1'b0, req_r.now_time} >= end_sum);

  // released mask at response width
  for (genvar b = 0; b < MASK_W; b++) begin : g_mask
    if (b < VOICE_SLOTS) begin : g_bit
      assign rel_mask[b] = rel_r[b];
    end else begin : g_pad
      assign rel_mask[b] = 1'b0;
    end
  end

  // sequencer and slot bookkeeping
  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    scan_idx_nxt    = scan_idx_r;
    chk_vld_nxt     = 1'b0;
    chk_idx_nxt     = chk_idx_r;
    slot_active_nxt = slot_active_r;
    active_cnt_nxt  = active_cnt_r;
    res_grant_nxt   = res_grant_r;
    res_slot_nxt    = res_slot_r;
    rel_nxt         = rel_r;
    out_vld_nxt     = out_vld_r;
    out_rsp_nxt     = out_rsp_r;
    mem_we          = 1'b0;

    // response taken downstream
    if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          req_nxt       = in_chan.req;
          scan_idx_nxt  = '0;
          res_grant_nxt = 1'b0;
          res_slot_nxt  = '0;
          rel_nxt       = '0;
          state_nxt     = (in_chan.req.opcode == OP_TIME) ? ST_TIME : ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        if (!slot_active_r[scan_idx_r]) begin
          mem_we                      = 1'b1;
          slot_active_nxt[scan_idx_r] = 1'b1;
          active_cnt_nxt              = active_cnt_r + CNT_W'(1);
          res_grant_nxt               = 1'b1;
          res_slot_nxt                = scan_idx_r;
          state_nxt                   = ST_DONE;
        end else if (scan_idx_r == LAST_IDX) begin
          state_nxt = ST_DONE;
        end else begin
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
        end
      end
      ST_TIME: begin
        chk_vld_nxt = 1'b1;
        chk_idx_nxt = scan_idx_r;
        if (scan_idx_r == LAST_IDX) begin
          state_nxt = ST_TAIL;
        end else begin
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
        end
      end
      ST_TAIL: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_r || out_chan.ready) begin
          out_vld_nxt               = 1'b1;
          out_rsp_nxt.granted       = res_grant_r;
          out_rsp_nxt.slot_number   = SLOT_NUM_W'(res_slot_r);
          out_rsp_nxt.busy_count    = BUSY_W'(active_cnt_r);
          out_rsp_nxt.released_mask = rel_mask;
          state_nxt                 = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // expiry check, one slot behind the memory read
    if (chk_vld_r && slot_active_r[chk_idx_r] && expire) begin
      slot_active_nxt[chk_idx_r] = 1'b0;
      active_cnt_nxt             = active_cnt_r - CNT_W'(1);
      rel_nxt[chk_idx_r]         = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      chk_vld_r     <= 1'b0;
      slot_active_r <= '0;
      active_cnt_r  <= '0;
      out_vld_r     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      chk_vld_r     <= chk_vld_nxt;
      slot_active_r <= slot_active_nxt;
      active_cnt_r  <= active_cnt_nxt;
      out_vld_r     <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    scan_idx_r  <= scan_idx_nxt;
    chk_idx_r   <= chk_idx_nxt;
    res_grant_r <= res_grant_nxt;
    res_slot_r  <= res_slot_nxt;
    rel_r       <= rel_nxt;
    out_rsp_r   <= out_rsp_nxt;
  end

  // record memory write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[scan_idx_r] <= wr_rec;
    end
  end

  // record memory read port
  always_ff @(posedge clk) begin
    rd_rec_r <= slot_mem[scan_idx_r];
  end

  // channel outputs
  assign in_chan.ready = (state_r == ST_IDLE);
  assign out_chan.valid = out_vld_r;
  assign out_chan.rsp   = out_rsp_r;

endmodule
`default_nettype wire

// File: hw/rtl/vsa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vsa_checker
// Port-level checks of the voice slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module vsa_checker import vsa_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic                  granted,
  input wire logic [SLOT_NUM_W-1:0] slot_number,
  input wire logic [BUSY_W-1:0]     busy_count,
  input wire logic [MASK_W-1:0]     released_mask
);

  // a pending response stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("response dropped before it was taken");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  // a grant releases nothing and leaves at least one voice busy
  a_grant_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && granted |-> released_mask == '0 && busy_count != '0)
    else $error("grant response with release mask or zero count");

  // no slot number without a grant
  a_refuse_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !granted |-> slot_number == '0)
    else $error("slot number reported without a grant");

endmodule

bind voice_slot_allocator vsa_checker u_vsa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .granted       (out_chan.rsp.granted),
  .slot_number   (out_chan.rsp.slot_number),
  .busy_count    (out_chan.rsp.busy_count),
  .released_mask (out_chan.rsp.released_mask)
);
`default_nettype wire
